// File: sv/pmid_pkg.sv
`timescale 1ns / 1ps
package pmid_pkg;
  localparam int SLOT_W = 10;
  localparam int POS_W = 32;
  localparam int D_W = 33;
  localparam int ENT_W = 21;
  localparam int REG_W = 63;
  localparam int DIST_W = 34;
  localparam int FRAC_F = 16;
  localparam int RECIP_FRAC = 20;
  localparam int BASIS_FRAC = 8;
  localparam int CELL_W = 22;
  localparam int IMG_W = 60;
  localparam int SQ_W = 122;
  localparam int ROOT_W = 61;
  localparam logic [2:0] CFG_BASIS0 = 3'd0;
  localparam logic [2:0] CFG_BASIS1 = 3'd1;
  localparam logic [2:0] CFG_BASIS2 = 3'd2;
  localparam logic [2:0] CFG_RECIP0 = 3'd3;
  localparam logic [2:0] CFG_RECIP1 = 3'd4;
  localparam logic [2:0] CFG_RECIP2 = 3'd5;

  typedef logic signed [D_W-1:0] disp_t;

  function automatic logic signed [ENT_W-1:0] entry_f(input logic [REG_W-1:0] r,
                                                      input int k);
    return r[ENT_W*k +: ENT_W];
  endfunction
endpackage

// File: sv/pmid_sqrt.sv
`timescale 1ns / 1ps
module pmid_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [pmid_pkg::SQ_W-1:0]    sq,
  output logic [pmid_pkg::DIST_W-1:0]  root
);
  import pmid_pkg::*;
  // digit-by-digit square root, 4 result bits per stage, 16 stages
  localparam int STG = 16;
  localparam int BPS = 4;
  localparam int XW = 2 * STG * BPS;
  localparam int RW = ROOT_W + 3;
  logic [XW-1:0]     rad_s [STG+1];
  logic [RW-1:0]     rem_s [STG+1];
  logic [ROOT_W-1:0] res_s [STG+1];

  assign rad_s[0] = XW'(sq);
  assign rem_s[0] = '0;
  assign res_s[0] = '0;

  for (genvar s = 0; s < STG; s++) begin : g_stg
    logic [XW-1:0]     rad_nxt;
    logic [RW-1:0]     rem_nxt;
    logic [ROOT_W-1:0] res_nxt;
    logic [XW-1:0]     rad_r;
    logic [RW-1:0]     rem_r;
    logic [ROOT_W-1:0] res_r;
    always_comb begin
      logic [RW-1:0] trial;
      rad_nxt = rad_s[s];
      rem_nxt = rem_s[s];
      res_nxt = res_s[s];
      for (int j = 0; j < BPS; j++) begin
        // bring down the next two radicand bits
        rem_nxt = {rem_nxt[RW-3:0], rad_nxt[XW-1:XW-2]};
        rad_nxt = rad_nxt << 2;
        trial = RW'({res_nxt, 2'b01});
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          res_nxt = {res_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          res_nxt = {res_nxt[ROOT_W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rad_r <= rad_nxt;
        rem_r <= rem_nxt;
        res_r <= res_nxt;
      end
    end
    assign rad_s[s+1] = rad_r;
    assign rem_s[s+1] = rem_r;
    assign res_s[s+1] = res_r;
  end

  assign root = (|res_s[STG][ROOT_W-1:DIST_W]) ? {DIST_W{1'b1}} : res_s[STG][DIST_W-1:0];
endmodule

// File: sv/periodic_minimum_image_distance.sv
`timescale 1ns / 1ps
// Periodic minimum-image distance engine.
// in_*: one request per pair: tdata holds pair_slot, first_x/y/z, second_x/y/z.
// out_*: tdata holds changed, raw_distance, image_distance, image_dx/dy/dz.
// cfg_*: register writes (index 0..2 basis rows, 3..5 reciprocal rows); write
// only while idle. Indexes above five are ignored.
// Throughput: one request per cycle unless stalled, through a stalling
// pipeline (slot read, compare, reciprocal and basis matrix stages, rounding,
// image, squares, sums of squares and a 16-stage square root at 4 bits per
// stage). The whole pipeline holds while out_tready is low and the last stage
// is full; nothing is lost or repeated. After reset a clearing pass zeros all
// 1024 slot entries; in_tready stays low meanwhile. Configuration resets to zero.
// The slot memory is read at entry and written at the compare stage; a request
// to the same slot close behind is served from a forwarding path.
module periodic_minimum_image_distance (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // slot[9:0], first_x, first_y, first_z, second_x, second_y, second_z; pad to 208
  input  logic [207:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // changed, raw_distance, image_distance, image_dx, image_dy, image_dz; pad to 168
  output logic [167:0]  out_tdata,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [62:0]   cfg_data
);
  import pmid_pkg::*;
  localparam int SLOTS = 1024;
  localparam int NST = 24;

  logic [REG_W-1:0] basis_r [3];
  logic [REG_W-1:0] recip_r [3];
  logic clr_busy_r;
  logic [SLOT_W-1:0] clr_cnt_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        basis_r[i] <= '0;
        recip_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index <= CFG_BASIS2) basis_r[cfg_index[1:0]] <= cfg_data;
      else if (cfg_index <= CFG_RECIP2) recip_r[2'(cfg_index - CFG_RECIP0)] <= cfg_data;
    end
  end

  logic adv;
  logic [NST-1:0] v_r;
  assign adv = !v_r[NST-1] || out_tready;
  assign in_tready = adv && !clr_busy_r;
  logic acc_in;
  assign acc_in = in_tvalid && in_tready;

  // stage 0: difference, memory read
  logic [3*D_W-1:0] mem [SLOTS];
  logic [SLOT_W-1:0] s0_slot_r;
  disp_t s0_d_r [3];
  logic [3*D_W-1:0] s0_prev_r;

  // stage 1 (compare / write) signals
  logic [SLOT_W-1:0] s1_slot_r;
  disp_t s1_d_r [3];
  logic s1_chg_r;
  logic [3*D_W-1:0] s0_prev_fwd;
  logic s1_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (&clr_cnt_r) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) mem[clr_cnt_r] <= '0;
    else if (s1_wr) mem[s1_slot_r] <= {s1_d_r[2], s1_d_r[1], s1_d_r[0]};
    if (adv) begin
      s0_prev_r <= mem[in_tdata[SLOT_W-1:0]];
      if (s1_wr && s1_slot_r == in_tdata[SLOT_W-1:0])
        s0_prev_r <= {s1_d_r[2], s1_d_r[1], s1_d_r[0]};
      s0_slot_r <= in_tdata[SLOT_W-1:0];
      for (int p = 0; p < 3; p++)
        s0_d_r[p] <= D_W'($signed(in_tdata[SLOT_W+POS_W*p +: POS_W]))
                   - D_W'($signed(in_tdata[SLOT_W+POS_W*(p+3) +: POS_W]));
    end
  end

  // forward stage-1 write to the item now in stage 0
  assign s0_prev_fwd = (s1_wr && s1_slot_r == s0_slot_r)
                     ? {s1_d_r[2], s1_d_r[1], s1_d_r[0]} : s0_prev_r;
  assign s1_wr = v_r[1] && s1_chg_r && adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_slot_r <= s0_slot_r;
      s1_d_r <= s0_d_r;
      s1_chg_r <= {s0_d_r[2], s0_d_r[1], s0_d_r[0]} != s0_prev_fwd;
    end
  end

  // stage 2: products recip[q][p]*d[q]
  logic signed [53:0] s2_pr_r [3][3];
  disp_t s2_d_r [3];
  logic s2_chg_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 3; p++)
        for (int q = 0; q < 3; q++)
          s2_pr_r[p][q] <= 54'(entry_f(recip_r[q], p)) * 54'(s1_d_r[q]);
      s2_d_r <= s1_d_r;
      s2_chg_r <= s1_chg_r;
    end
  end

  // stage 3: sum and round to even
  logic signed [CELL_W-1:0] s3_c_r [3];
  disp_t s3_d_r [3];
  logic s3_chg_r;
  localparam int SH = RECIP_FRAC + FRAC_F;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 3; p++) begin
        logic signed [55:0] a;
        logic signed [55:0] fl;
        logic [SH-1:0] fr;
        a = 56'(s2_pr_r[p][0]) + 56'(s2_pr_r[p][1]) + 56'(s2_pr_r[p][2]);
        fl = a >>> SH;
        fr = a[SH-1:0];
        if (fr[SH-1] && ((|fr[SH-2:0]) || fl[0])) fl = fl + 56'sd1;
        s3_c_r[p] <= CELL_W'(fl);
      end
      s3_d_r <= s2_d_r;
      s3_chg_r <= s2_chg_r;
    end
  end

  // stage 4: basis products
  logic signed [42:0] s4_pr_r [3][3];
  disp_t s4_d_r [3];
  logic s4_chg_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 3; p++)
        for (int q = 0; q < 3; q++)
          s4_pr_r[p][q] <= 43'(entry_f(basis_r[q], p)) * 43'(s3_c_r[q]);
      s4_d_r <= s3_d_r;
      s4_chg_r <= s3_chg_r;
    end
  end

  // stage 5: image displacement
  logic signed [IMG_W-1:0] s5_img_r [3];
  disp_t s5_d_r [3];
  logic s5_chg_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 3; p++) begin
        logic signed [IMG_W-1:0] b;
        b = IMG_W'(s4_pr_r[p][0]) + IMG_W'(s4_pr_r[p][1]) + IMG_W'(s4_pr_r[p][2]);
        s5_img_r[p] <= IMG_W'(s4_d_r[p]) - (b <<< (FRAC_F - BASIS_FRAC));
      end
      s5_d_r <= s4_d_r;
      s5_chg_r <= s4_chg_r;
    end
  end

  // stage 6: squares (image magnitude split into 30-bit halves)
  logic [65:0] s6_rsq_r [3];
  logic [59:0] s6_hh_r [3];
  logic [60:0] s6_hl_r [3];
  logic [59:0] s6_ll_r [3];
  logic signed [D_W-1:0] s6_img_r [3];
  logic s6_chg_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < 3; p++) begin
        logic [D_W-1:0] m;
        logic [IMG_W-1:0] mi;
        m = s5_d_r[p][D_W-1] ? D_W'(-s5_d_r[p]) : s5_d_r[p];
        mi = s5_img_r[p][IMG_W-1] ? IMG_W'(-s5_img_r[p]) : s5_img_r[p];
        s6_rsq_r[p] <= 66'(m) * 66'(m);
        s6_hh_r[p] <= 60'(mi[59:30]) * 60'(mi[59:30]);
        s6_hl_r[p] <= 61'(60'(mi[59:30]) * 60'(mi[29:0])) << 1;
        s6_ll_r[p] <= 60'(mi[29:0]) * 60'(mi[29:0]);
        if (s5_img_r[p] > IMG_W'(64'sd4294967295)) s6_img_r[p] <= {1'b0, {32{1'b1}}};
        else if (s5_img_r[p] < -IMG_W'(64'sd4294967296)) s6_img_r[p] <= {1'b1, 32'd0};
        else s6_img_r[p] <= D_W'(s5_img_r[p]);
      end
      s6_chg_r <= s5_chg_r;
    end
  end

  // stage 7: sums of squares
  logic [SQ_W-1:0] s7_rs_r, s7_is_r;
  logic signed [D_W-1:0] s7_img_r [3];
  logic s7_chg_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      logic [SQ_W-1:0] t;
      t = '0;
      for (int p = 0; p < 3; p++)
        t = t + (SQ_W'(s6_hh_r[p]) << 60) + (SQ_W'(s6_hl_r[p]) << 30) + SQ_W'(s6_ll_r[p]);
      s7_is_r <= t;
      s7_rs_r <= SQ_W'(s6_rsq_r[0]) + SQ_W'(s6_rsq_r[1]) + SQ_W'(s6_rsq_r[2]);
      s7_img_r <= s6_img_r;
      s7_chg_r <= s6_chg_r;
    end
  end

  logic [DIST_W-1:0] raw_d, img_d;
  pmid_sqrt u_sqrt_raw (.clk(clk), .en(adv), .sq(s7_rs_r), .root(raw_d));
  pmid_sqrt u_sqrt_img (.clk(clk), .en(adv), .sq(s7_is_r), .root(img_d));

  // delay line for sideband data across the 16 root stages
  logic signed [D_W-1:0] dl_img_r [16][3];
  logic dl_chg_r [16];
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_img_r[0] <= s7_img_r;
      dl_chg_r[0] <= s7_chg_r;
      for (int i = 1; i < 16; i++) begin
        dl_img_r[i] <= dl_img_r[i-1];
        dl_chg_r[i] <= dl_chg_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NST-2:0], acc_in};
  end

  logic chg;
  assign chg = dl_chg_r[15];
  assign out_tvalid = v_r[NST-1];
  always_comb begin
    out_tdata = '0;
    out_tdata[0] = chg;
    if (chg) begin
      out_tdata[1 +: DIST_W] = raw_d;
      out_tdata[35 +: DIST_W] = img_d;
      out_tdata[69 +: D_W] = dl_img_r[15][0];
      out_tdata[102 +: D_W] = dl_img_r[15][1];
      out_tdata[135 +: D_W] = dl_img_r[15][2];
    end
  end
endmodule

// File: verif/pmid_checker.sv
`timescale 1ns / 1ps
module pmid_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [207:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [167:0] out_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [62:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  import pmid_pkg::*;

  typedef struct packed {
    logic               changed;
    logic [DIST_W-1:0]  raw_dist;
    logic [DIST_W-1:0]  img_dist;
    logic signed [32:0] img_dx;
    logic signed [32:0] img_dy;
    logic signed [32:0] img_dz;
  } dist_result_t;

  logic [REG_W-1:0] basis_q [3];
  logic [REG_W-1:0] recip_q [3];
  logic signed [D_W-1:0] last_disp [1024][3];
  dist_result_t expected_q [$];

  assign pending = expected_q.size();

  function automatic logic signed [ENT_W-1:0] cell_entry(input logic [REG_W-1:0] r,
                                                         input int k);
    cell_entry = ENT_W'(r >> (ENT_W * k));
  endfunction

  // round v / 2^s to the nearest integer, ties to even
  function automatic logic signed [63:0] round_ties_even(input logic signed [127:0] v,
                                                          input int s);
    logic signed [127:0] fl;
    logic signed [127:0] rem;
    logic signed [127:0] half;
    fl = v >>> s;
    rem = v - (fl <<< s);
    half = 128'sd1 <<< (s - 1);
    if (rem > half || (rem == half && fl[0]))
      fl = fl + 1;
    return fl[63:0];
  endfunction

  function automatic logic [DIST_W-1:0] vec_length(input logic signed [127:0] x,
                                                   input logic signed [127:0] y,
                                                   input logic signed [127:0] z);
    logic [255:0] sum;
    logic [127:0] root;
    logic [127:0] cand;
    sum = x * x + y * y + z * z;
    root = 0;
    for (int b = 70; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sum)
        root = cand;
    end
    if (root > {DIST_W{1'b1}})
      return {DIST_W{1'b1}};
    return root[DIST_W-1:0];
  endfunction

  function automatic logic signed [32:0] sat_img(input logic signed [127:0] v);
    if (v > 128'sd4294967295)
      return 33'sh0_FFFF_FFFF;
    if (v < -128'sd4294967296)
      return 33'sh1_0000_0000;
    return v[32:0];
  endfunction

  function automatic dist_result_t predict_distance(input logic [207:0] req);
    dist_result_t r;
    logic [SLOT_W-1:0] slot;
    logic signed [127:0] d [3];
    logic signed [127:0] acc;
    logic signed [127:0] cell_idx [3];
    logic signed [127:0] img [3];
    slot = req[SLOT_W-1:0];
    for (int p = 0; p < 3; p++)
      d[p] = $signed(req[SLOT_W + POS_W*p +: POS_W])
             - $signed(req[SLOT_W + POS_W*(p+3) +: POS_W]);
    r = '0;
    if (d[0] == last_disp[slot][0] && d[1] == last_disp[slot][1]
        && d[2] == last_disp[slot][2])
      return r;
    for (int p = 0; p < 3; p++)
      last_disp[slot][p] = d[p][D_W-1:0];
    for (int p = 0; p < 3; p++) begin
      acc = 0;
      for (int q = 0; q < 3; q++)
        acc += cell_entry(recip_q[q], p) * d[q];
      cell_idx[p] = round_ties_even(acc, RECIP_FRAC + FRAC_F);
    end
    for (int p = 0; p < 3; p++) begin
      acc = 0;
      for (int q = 0; q < 3; q++)
        acc += cell_entry(basis_q[q], p) * cell_idx[q];
      img[p] = d[p] - (acc <<< (FRAC_F - BASIS_FRAC));
    end
    r.changed = 1'b1;
    r.raw_dist = vec_length(d[0], d[1], d[2]);
    r.img_dist = vec_length(img[0], img[1], img[2]);
    r.img_dx = sat_img(img[0]);
    r.img_dy = sat_img(img[1]);
    r.img_dz = sat_img(img[2]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    for (int i = 0; i < 3; i++) begin
      basis_q[i] = '0;
      recip_q[i] = '0;
    end
    for (int i = 0; i < 1024; i++)
      for (int p = 0; p < 3; p++)
        last_disp[i][p] = '0;
  end

  always @(posedge clk) begin
    dist_result_t want;
    dist_result_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= CFG_BASIS2)
          basis_q[cfg_index[1:0]] = cfg_data;
        else if (cfg_index <= CFG_RECIP2)
          recip_q[2'(cfg_index - CFG_RECIP0)] = cfg_data;
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_distance(in_tdata));
      if (out_tvalid && out_tready) begin
        got.changed = out_tdata[0];
        got.raw_dist = out_tdata[1 +: DIST_W];
        got.img_dist = out_tdata[1 + DIST_W +: DIST_W];
        got.img_dx = out_tdata[1 + 2*DIST_W +: 33];
        got.img_dy = out_tdata[1 + 2*DIST_W + 33 +: 33];
        got.img_dz = out_tdata[1 + 2*DIST_W + 66 +: 33];
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 64'(got.raw_dist), 64'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.changed !== want.changed)
            report_mismatch("changed", 64'(got.changed), 64'(want.changed));
          if (got.raw_dist !== want.raw_dist)
            report_mismatch("raw_distance", 64'(got.raw_dist), 64'(want.raw_dist));
          if (got.img_dist !== want.img_dist)
            report_mismatch("image_distance", 64'(got.img_dist), 64'(want.img_dist));
          if (got.img_dx !== want.img_dx)
            report_mismatch("image_dx", 64'(got.img_dx), 64'(want.img_dx));
          if (got.img_dy !== want.img_dy)
            report_mismatch("image_dy", 64'(got.img_dy), 64'(want.img_dy));
          if (got.img_dz !== want.img_dz)
            report_mismatch("image_dz", 64'(got.img_dz), 64'(want.img_dz));
        end
      end
    end
  end

endmodule

// File: verif/tb_periodic_minimum_image_distance.sv
`timescale 1ns / 1ps
module tb_periodic_minimum_image_distance;
  import pmid_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [207:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [167:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [62:0] cfg_data = '0;
  int fail_count;
  int pending;
  int cycle_count = 0;
  logic signed [31:0] slot_pos [1024][6];

  always #2 clk = ~clk;

  periodic_minimum_image_distance dut (.*);

  pmid_checker chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // random receiver stalls, with calm stretches
  initial begin
    int wait_n;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 7) == 0) begin
        wait_n = $urandom_range(0, 17);
        if (wait_n != 0) begin
          out_tready <= 0;
          repeat (wait_n) @(negedge clk);
        end
      end
      out_tready <= 1;
      repeat ($urandom_range(0, 20)) @(negedge clk);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [62:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  function automatic logic [62:0] pack3(input int a, input int b, input int c);
    return {c[20:0], b[20:0], a[20:0]};
  endfunction

  // leaves in_tvalid high; drain, or a gap before the next request, drops it
  task automatic send_pair(input logic [9:0] slot, input logic [31:0] f [3],
                           input logic [31:0] s [3], input bit burst);
    int gap;
    gap = 0;
    if (!burst && $urandom_range(0, 3) == 0)
      gap = $urandom_range(0, 17);
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {6'b0, s[2], s[1], s[0], f[2], f[1], f[0], slot};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pos(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [31:0] f [3];
    logic [31:0] s [3];
    logic [9:0] slot;
    int mode;
    for (int n = 0; n < count; n++) begin
      slot = $urandom_range(0, 1023);
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        // repeat last positions for this slot so the unchanged path is hit
        for (int p = 0; p < 3; p++) begin
          f[p] = slot_pos[slot][p];
          s[p] = slot_pos[slot][p+3];
        end
        if (mode == 1 && $urandom_range(0, 1))
          for (int p = 0; p < 3; p++) begin
            f[p] = f[p] + 32'd5;
            s[p] = s[p] + 32'd5;
          end
      end else begin
        for (int p = 0; p < 3; p++) begin
          f[p] = rand_pos(mode < 4 ? 0 : (mode < 9 ? 1 : 2));
          s[p] = rand_pos(mode < 4 ? 0 : (mode < 9 ? 1 : 2));
        end
      end
      for (int p = 0; p < 3; p++) begin
        slot_pos[slot][p] = f[p];
        slot_pos[slot][p+3] = s[p];
      end
      send_pair(slot, f, s, n % 200 < 30);
    end
  endtask

  task automatic set_cell(input int len, input int skew);
    // cubic-ish cell of len (8 fraction bits) with a small skew, and its inverse
    int inv;
    inv = (1 << 28) / len;
    write_reg(CFG_BASIS0, pack3(len, 0, 0));
    write_reg(CFG_BASIS1, pack3(skew, len, 0));
    write_reg(CFG_BASIS2, pack3(0, skew, len));
    write_reg(CFG_RECIP0, pack3(inv, 0, 0));
    write_reg(CFG_RECIP1, pack3(-((skew * inv) / len), inv, 0));
    write_reg(CFG_RECIP2, pack3(0, -((skew * inv) / len), inv));
  endtask

  initial begin
    logic [31:0] f [3];
    logic [31:0] s [3];
    for (int i = 0; i < 1024; i++)
      for (int p = 0; p < 6; p++)
        slot_pos[i][p] = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1;

    // zero registers: image equals raw displacement
    f = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    s = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_pair(10'd0, f, s, 1);
    send_pair(10'd0, f, s, 1);
    send_pair(10'd1023, s, f, 1);
    f = '{0, 0, 0};
    s = '{0, 0, 0};
    send_pair(10'd5, f, s, 1);
    f = '{32'h0001_0000, 0, 0};
    send_pair(10'd5, f, s, 1);
    drain();

    // extreme register values
    write_reg(CFG_BASIS0, 63'h7FFF_FFFF_FFFF_FFFF);
    write_reg(CFG_BASIS1, pack3(-1048576, 1048575, -1048576));
    write_reg(CFG_BASIS2, pack3(1048575, -1048576, 1048575));
    write_reg(CFG_RECIP0, pack3(1048575, -1048576, 1048575));
    write_reg(CFG_RECIP1, 63'h7FFF_FFFF_FFFF_FFFF);
    write_reg(CFG_RECIP2, pack3(-1048576, 1048575, -1048576));
    write_reg(CFG_UNUSED, 63'h1234_5678);
    f = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    s = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send_pair(10'd2, f, s, 1);
    send_pair(10'd3, s, f, 0);
    random_phase(150);
    drain();

    // cell of 16 units: exact half-cell ties land on even
    set_cell(16 << 8, 0);
    f = '{32'h0008_0000, 32'h0018_0000, 32'hFFF8_0000};
    s = '{0, 0, 0};
    send_pair(10'd7, f, s, 1);
    f = '{32'h0028_0000, 32'h0001_0000, 32'h0010_0000};
    send_pair(10'd8, f, s, 1);
    random_phase(450);
    drain();

    // skewed cell
    set_cell(40 << 8, 7 << 8);
    random_phase(450);
    // hold off until all outstanding results arrive
    drain();

    set_cell(3 << 8, -(1 << 8));
    random_phase(450);
    drain();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pmid_pkg.sv
sv/pmid_sqrt.sv
sv/periodic_minimum_image_distance.sv
verif/pmid_checker.sv
verif/tb_periodic_minimum_image_distance.sv
